// ===== src/transposition_table_store_probe_macros.svh =====
`ifndef TRANSPOSITION_TABLE_STORE_PROBE_MACROS_SVH
`define TRANSPOSITION_TABLE_STORE_PROBE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttsp check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TTSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttsp check failed");

`endif

// ===== src/ttsp_pkg.sv =====
`default_nettype none

package ttsp_pkg;

  localparam int SLOT_COUNT_LOG2 = 10;
  localparam int SLOT_COUNT = 1 << SLOT_COUNT_LOG2;

  localparam logic [6:0] NO_SQUARE = 7'd127;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  typedef logic [SLOT_COUNT_LOG2-1:0] slot_idx_t;

  typedef struct packed {
    logic [6:0]         move_to;
    logic [6:0]         move_origin;
    logic signed [31:0] score;
    logic [1:0]         kind;
    logic [6:0]         depth;
  } slot_payload_t;

  typedef struct packed {
    logic          valid;
    logic [63:0]   key;
    slot_payload_t payload;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SWEEP
  } ctrl_state_t;

  typedef struct packed {
    logic ready;
    logic commit;
    logic sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic op_clear;
    logic out_stall;
    logic sweep_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/ttsp_if.sv =====
`default_nettype none

interface ttsp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [63:0]        position_key;
  logic [6:0]         search_depth;
  logic [1:0]         bound_kind;
  logic signed [31:0] store_score;
  logic signed [31:0] window_low;
  logic signed [31:0] window_high;
  logic [6:0]         move_origin;
  logic [6:0]         move_to;

  modport source (
    output valid, operation, position_key, search_depth, bound_kind,
           store_score, window_low, window_high, move_origin, move_to,
    input  ready
  );
  modport sink (
    input  valid, operation, position_key, search_depth, bound_kind,
           store_score, window_low, window_high, move_origin, move_to,
    output ready
  );
endinterface

interface ttsp_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               score_usable;
  logic signed [31:0] found_score;
  logic [6:0]         best_from;
  logic [6:0]         best_to;

  modport source (
    output valid, hit, score_usable, found_score, best_from, best_to,
    input  ready
  );
  modport sink (
    input  valid, hit, score_usable, found_score, best_from, best_to,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/transposition_table_store_probe.sv =====
`default_nettype none
// channel  | role   | payload
// in_item  | sink   | operation, position_key, search_depth, bound_kind, scores, move
// out_item | source | hit, score_usable, found_score, best_from, best_to
//
// Store and probe: the slot is read on accept, then evaluated and written back.
// Clear: its result leaves, then the valid bits of all 1024 slots are swept
// one slot per cycle through the single write port.
// After reset the same sweep runs before the first item is taken.
// A held result stalls the evaluate cycle; one result waits in the output register.

`include "transposition_table_store_probe_macros.svh"

module transposition_table_store_probe (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ttsp_in_if.sink    in_item,
  ttsp_out_if.source out_item
);

  ttsp_pkg::ctrl_cmd_t cmd;
  ttsp_pkg::ctrl_sts_t sts;

  ttsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ttsp_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item)
  );

  `TTSP_ASSERT_NEXT(a_one_item_in_flight, in_item.valid && in_item.ready, !in_item.ready)
  `TTSP_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_item.valid)
  `TTSP_ASSERT_NEXT(a_sweep_runs_through, cmd.sweep && !sts.sweep_last, cmd.sweep)
  `TTSP_ASSERT_NOW(a_no_write_clash, cmd.sweep, !cmd.commit && !cmd.ready)

endmodule

`default_nettype wire

// ===== src/ttsp_datapath.sv =====
`default_nettype none

module ttsp_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ttsp_pkg::ctrl_cmd_t cmd,
  output ttsp_pkg::ctrl_sts_t      sts,
  ttsp_in_if.sink                  in_item,
  ttsp_out_if.source               out_item
);

  ttsp_pkg::slot_entry_t mem_r [ttsp_pkg::SLOT_COUNT];
  ttsp_pkg::slot_entry_t rd_r;

  logic [1:0]          op_r;
  logic [63:0]         key_r;
  logic [6:0]          depth_r;
  logic [1:0]          kind_r;
  logic signed [31:0]  score_r;
  logic signed [31:0]  alpha_r;
  logic signed [31:0]  beta_r;
  logic [6:0]          from_r;
  logic [6:0]          to_r;

  ttsp_pkg::slot_idx_t sweep_cnt_r;
  ttsp_pkg::slot_idx_t rd_idx;
  ttsp_pkg::slot_idx_t wr_idx;
  ttsp_pkg::slot_entry_t wr_data;
  logic                wr_en;
  logic                capture;

  logic                key_match;
  logic                replace;
  logic                depth_ok;
  logic                usable;
  logic                hit;

  logic                out_valid_r;
  logic                hit_r;
  logic                usable_r;
  logic signed [31:0]  found_r;
  logic [6:0]          best_from_r;
  logic [6:0]          best_to_r;

  assign capture = cmd.ready & in_item.valid;
  assign in_item.ready = cmd.ready;
  assign rd_idx = in_item.position_key[ttsp_pkg::SLOT_COUNT_LOG2-1:0];

  always_ff @(posedge clk) begin
    if (capture) begin
      op_r    <= in_item.operation;
      key_r   <= in_item.position_key;
      depth_r <= in_item.search_depth;
      kind_r  <= in_item.bound_kind;
      score_r <= in_item.store_score;
      alpha_r <= in_item.window_low;
      beta_r  <= in_item.window_high;
      from_r  <= in_item.move_origin;
      to_r    <= in_item.move_to;
      rd_r    <= mem_r[rd_idx];
    end
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  assign key_match = rd_r.valid && (rd_r.key == key_r);
  assign replace   = !key_match || (depth_r >= rd_r.payload.depth);
  assign hit       = (op_r == ttsp_pkg::OP_PROBE) && key_match;
  assign depth_ok  = rd_r.payload.depth >= depth_r;

  always_comb begin
    case (rd_r.payload.kind)
      ttsp_pkg::BOUND_EXACT: usable = depth_ok;
      ttsp_pkg::BOUND_LOWER: usable = depth_ok && (rd_r.payload.score >= beta_r);
      ttsp_pkg::BOUND_UPPER: usable = depth_ok && (rd_r.payload.score <= alpha_r);
      default:               usable = 1'b0;
    endcase
  end

  always_comb begin
    wr_data = '0;
    wr_idx  = sweep_cnt_r;
    wr_en   = 1'b0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.commit && (op_r == ttsp_pkg::OP_STORE) && replace) begin
      wr_en                 = 1'b1;
      wr_idx                = key_r[ttsp_pkg::SLOT_COUNT_LOG2-1:0];
      wr_data.valid         = 1'b1;
      wr_data.key           = key_r;
      wr_data.payload.depth = depth_r;
      wr_data.payload.kind  = kind_r;
      wr_data.payload.score = score_r;
      if (from_r == ttsp_pkg::NO_SQUARE) begin
        wr_data.payload.move_origin = ttsp_pkg::NO_SQUARE;
        wr_data.payload.move_to     = ttsp_pkg::NO_SQUARE;
      end else begin
        wr_data.payload.move_origin = from_r;
        wr_data.payload.move_to     = to_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r    <= hit;
      usable_r <= hit && usable;
      found_r  <= (hit && usable) ? rd_r.payload.score : 32'sd0;
      if (hit) begin
        best_from_r <= rd_r.payload.move_origin;
        best_to_r   <= rd_r.payload.move_to;
      end else begin
        best_from_r <= ttsp_pkg::NO_SQUARE;
        best_to_r   <= ttsp_pkg::NO_SQUARE;
      end
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.hit          = hit_r;
  assign out_item.score_usable = usable_r;
  assign out_item.found_score  = found_r;
  assign out_item.best_from    = best_from_r;
  assign out_item.best_to      = best_to_r;

  assign sts.item_valid = in_item.valid;
  assign sts.op_clear   = op_r == ttsp_pkg::OP_CLEAR;
  assign sts.out_stall  = out_valid_r & ~out_item.ready;
  assign sts.sweep_last = &sweep_cnt_r;

endmodule

`default_nettype wire

// ===== src/ttsp_ctrl.sv =====
`default_nettype none

module ttsp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ttsp_pkg::ctrl_sts_t sts,
  output ttsp_pkg::ctrl_cmd_t      cmd
);

  ttsp_pkg::ctrl_state_t state_r;
  ttsp_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttsp_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ttsp_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.item_valid) begin
          state_nxt = ttsp_pkg::ST_EVAL;
        end
      end
      ttsp_pkg::ST_EVAL: begin
        if (!sts.out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.op_clear ? ttsp_pkg::ST_SWEEP : ttsp_pkg::ST_IDLE;
        end
      end
      ttsp_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ttsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/transposition_table_store_probe_test.sv =====
`default_nettype none

module transposition_table_store_probe_test;
  import ttsp_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] BOUND_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 1100;
  localparam int KEY_POOL = 24;
  localparam int SLOT_POOL = 8;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]         op;
    logic [63:0]        key;
    logic [6:0]         depth;
    logic [1:0]         kind;
    logic signed [31:0] score;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic [6:0]         from_sq;
    logic [6:0]         to_sq;
  } tt_request_t;

  typedef struct packed {
    logic               hit;
    logic               usable;
    logic signed [31:0] score;
    logic [6:0]         from_sq;
    logic [6:0]         to_sq;
  } tt_answer_t;

  typedef struct packed {
    tt_request_t item;
    logic        typed;
    tt_answer_t  want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  ttsp_in_if  in_ch();
  ttsp_out_if out_ch();

  transposition_table_store_probe DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch),
    .out_item(out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  bit [SLOT_COUNT-1:0] slot_valid;
  logic [63:0]         slot_key [SLOT_COUNT];
  slot_payload_t       slot_data [SLOT_COUNT];

  tt_answer_t  answers_due[$];
  int unsigned send_gap_pct = 18;
  int unsigned take_gap_pct = 60;
  int          fail_count = 0;
  int          n_stores = 0;
  int          n_probes = 0;
  int          n_hits = 0;
  int          n_usable = 0;
  int          n_clears = 0;
  int          n_unused = 0;

  function automatic tt_request_t make_item(
    input logic [1:0] op, input logic [63:0] key, input logic [6:0] depth,
    input logic [1:0] kind, input logic signed [31:0] score,
    input logic signed [31:0] alpha, input logic signed [31:0] beta,
    input logic [6:0] from_sq, input logic [6:0] to_sq);
    tt_request_t r;
    r.op = op;
    r.key = key;
    r.depth = depth;
    r.kind = kind;
    r.score = score;
    r.alpha = alpha;
    r.beta = beta;
    r.from_sq = from_sq;
    r.to_sq = to_sq;
    return r;
  endfunction

  function automatic tt_answer_t answer(input logic hit, input logic usable,
                                        input logic signed [31:0] score,
                                        input logic [6:0] from_sq,
                                        input logic [6:0] to_sq);
    tt_answer_t a;
    a.hit = hit;
    a.usable = usable;
    a.score = score;
    a.from_sq = from_sq;
    a.to_sq = to_sq;
    return a;
  endfunction

  function automatic tt_answer_t table_answer(input tt_request_t r);
    slot_idx_t     idx;
    slot_payload_t p;
    tt_answer_t    a;
    logic          usable;
    idx = r.key[SLOT_COUNT_LOG2-1:0];
    a = answer(1'b0, 1'b0, 32'sd0, NO_SQUARE, NO_SQUARE);
    case (r.op)
      OP_STORE: begin
        n_stores++;
        if (!slot_valid[idx] || slot_key[idx] != r.key || r.depth >= slot_data[idx].depth) begin
          p.depth = r.depth;
          p.kind = r.kind;
          p.score = r.score;
          p.move_origin = r.from_sq;
          p.move_to = (r.from_sq == NO_SQUARE) ? NO_SQUARE : r.to_sq;
          slot_valid[idx] = 1'b1;
          slot_key[idx] = r.key;
          slot_data[idx] = p;
        end
      end
      OP_PROBE: begin
        n_probes++;
        if (slot_valid[idx] && slot_key[idx] == r.key) begin
          p = slot_data[idx];
          usable = 1'b0;
          if (p.depth >= r.depth) begin
            case (p.kind)
              BOUND_EXACT: usable = 1'b1;
              BOUND_LOWER: usable = $signed(p.score) >= $signed(r.beta);
              BOUND_UPPER: usable = $signed(p.score) <= $signed(r.alpha);
              default:     usable = 1'b0;
            endcase
          end
          a = answer(1'b1, usable, usable ? p.score : 32'sd0, p.move_origin, p.move_to);
          n_hits++;
          if (usable) n_usable++;
        end
      end
      OP_CLEAR: begin
        n_clears++;
        slot_valid = '0;
      end
      default: begin
        n_unused++;
      end
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(9))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(40)) - 32'sd20;
    endcase
  endfunction

  task automatic offer(input tt_request_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= r.op;
    in_ch.position_key <= r.key;
    in_ch.search_depth <= r.depth;
    in_ch.bound_kind   <= r.kind;
    in_ch.store_score  <= r.score;
    in_ch.window_low   <= r.alpha;
    in_ch.window_high  <= r.beta;
    in_ch.move_origin  <= r.from_sq;
    in_ch.move_to      <= r.to_sq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    directed_row_t rows[$];
    tt_request_t   r;
    tt_answer_t    a;
    logic [63:0]   key_pool [KEY_POOL];
    slot_idx_t     slot_pool [SLOT_POOL];
    int            sent;
    int            pick;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_STORE;
    in_ch.position_key <= '0;
    in_ch.search_depth <= '0;
    in_ch.bound_kind   <= BOUND_EXACT;
    in_ch.store_score  <= '0;
    in_ch.window_low   <= '0;
    in_ch.window_high  <= '0;
    in_ch.move_origin  <= '0;
    in_ch.move_to      <= '0;

    for (int k = 0; k < SLOT_POOL; k++) slot_pool[k] = slot_idx_t'($urandom_range(SLOT_COUNT - 1));
    for (int k = 0; k < KEY_POOL; k++) begin
      key_pool[k] = {$urandom, $urandom};
      key_pool[k][SLOT_COUNT_LOG2-1:0] = slot_pool[k % SLOT_POOL];
    end

    // empty table, extremes, bound rules, missing move, replacement, clear
    rows.push_back('{make_item(OP_PROBE, 64'd0, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_STORE, 64'd0, 7'd0, BOUND_EXACT, SCORE_MIN, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd0, 7'd0, BOUND_EXACT, 0, SCORE_MIN, SCORE_MAX, 0, 0),
                     1'b1, answer(1'b1, 1'b1, SCORE_MIN, 7'd0, 7'd0)});
    rows.push_back('{make_item(OP_STORE, '1, 7'd127, BOUND_LOWER, SCORE_MAX, 0, 0, 7'd5, 7'd126),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, '1, 7'd127, BOUND_EXACT, 0, SCORE_MIN, SCORE_MAX, 0, 0),
                     1'b1, answer(1'b1, 1'b1, SCORE_MAX, 7'd5, 7'd126)});
    rows.push_back('{make_item(OP_STORE, 64'd1, 7'd10, BOUND_LOWER, 100, 0, 0, NO_SQUARE, 7'd33),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd1, 7'd10, BOUND_EXACT, 0, 0, 100, 0, 0),
                     1'b1, answer(1'b1, 1'b1, 100, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd1, 7'd10, BOUND_EXACT, 0, 0, 101, 0, 0),
                     1'b1, answer(1'b1, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd1, 7'd11, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b1, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_STORE, 64'd2, 7'd20, BOUND_UPPER, -50, 0, 0, 7'd12, 7'd28),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd2, 7'd20, BOUND_EXACT, 0, -50, 0, 0, 0),
                     1'b1, answer(1'b1, 1'b1, -50, 7'd12, 7'd28)});
    rows.push_back('{make_item(OP_PROBE, 64'd2, 7'd0, BOUND_EXACT, 0, -51, 0, 0, 0),
                     1'b1, answer(1'b1, 1'b0, 0, 7'd12, 7'd28)});
    rows.push_back('{make_item(OP_STORE, 64'd3, 7'd5, BOUND_NONE, 7, 0, 0, 7'd1, 7'd2),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd3, 7'd0, BOUND_EXACT, 0, SCORE_MAX, SCORE_MIN, 0, 0),
                     1'b1, answer(1'b1, 1'b0, 0, 7'd1, 7'd2)});
    rows.push_back('{make_item(OP_STORE, 64'h402, 7'd0, BOUND_EXACT, 9, 0, 0, 7'd40, 7'd41),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd2, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'h402, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_STORE, 64'd1, 7'd9, BOUND_EXACT, 300, 0, 0, 7'd3, 7'd4),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd1, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_STORE, 64'd1, 7'd10, BOUND_EXACT, 200, 0, 0, 7'd64, 7'd65),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd1, 7'd10, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b0, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_NONE, 64'd1, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_CLEAR, 64'd0, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, 64'd0, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});
    rows.push_back('{make_item(OP_PROBE, '1, 7'd0, BOUND_EXACT, 0, 0, 0, 0, 0),
                     1'b1, answer(1'b0, 1'b0, 0, NO_SQUARE, NO_SQUARE)});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      offer(rows[i].item);
      a = table_answer(rows[i].item);
      answers_due.push_back(rows[i].typed ? rows[i].want : a);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_gap_pct = 18;
        take_gap_pct = 60;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct = 60;
        take_gap_pct = 18;
      end else begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end

      pick = $urandom_range(999);
      if (pick < 10) r.op = OP_CLEAR;
      else if (pick < 50) r.op = OP_NONE;
      else if (pick < 500) r.op = OP_STORE;
      else r.op = OP_PROBE;
      r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                        : {$urandom, $urandom};
      r.depth = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
      r.kind = ($urandom_range(9) == 0) ? BOUND_NONE : 2'($urandom_range(2));
      r.score = pick_score();
      r.alpha = pick_score();
      r.beta = pick_score();
      r.from_sq = ($urandom_range(99) < 15) ? NO_SQUARE : 7'($urandom_range(127));
      r.to_sq = 7'($urandom_range(127));

      offer(r);
      answers_due.push_back(table_answer(r));
      if (r.op != OP_NONE) sent++;
    end

    in_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d stores, %0d probes with %0d hits (%0d usable scores),",
             n_stores, n_probes, n_hits, n_usable);
    $display("%0d table clears and %0d unused operations under three idle mixes.",
             n_clears, n_unused);
    if (fail_count == 0) begin
      $display("[transposition_table_store_probe] OK");
    end else begin
      $display("[transposition_table_store_probe] ERROR");
    end
    $finish;
  end

  initial begin
    tt_answer_t exp_a;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected item: hit %0d found_score %0d", out_ch.hit,
                 $signed(out_ch.found_score));
          fail_count++;
        end else begin
          exp_a = answers_due.pop_front();
          if (out_ch.hit !== exp_a.hit) begin
            $error("hit: expected %0d, actual %0d", exp_a.hit, out_ch.hit);
            fail_count++;
          end
          if (out_ch.score_usable !== exp_a.usable) begin
            $error("score_usable: expected %0d, actual %0d", exp_a.usable, out_ch.score_usable);
            fail_count++;
          end
          if (out_ch.found_score !== exp_a.score) begin
            $error("found_score: expected %0d, actual %0d", $signed(exp_a.score),
                   $signed(out_ch.found_score));
            fail_count++;
          end
          if (out_ch.best_from !== exp_a.from_sq) begin
            $error("best_from: expected %0d, actual %0d", exp_a.from_sq, out_ch.best_from);
            fail_count++;
          end
          if (out_ch.best_to !== exp_a.to_sq) begin
            $error("best_to: expected %0d, actual %0d", exp_a.to_sq, out_ch.best_to);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  initial begin
    #(20 * 5000000);
    $display("[transposition_table_store_probe] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
